[rtl/bounded_partition_count_mod_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded partition counter
// Shorthand for clocked implications, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PARTITION_COUNT_MOD_ASSERT_SVH
`define BOUNDED_PARTITION_COUNT_MOD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bpcm_pkg.sv]
// ----------------------------------------------------------------------------
// bpcm_pkg
// Shared constants for the bounded partition counter.
// ----------------------------------------------------------------------------
package bpcm_pkg;

  localparam int unsigned MAX_N   = 1024;
  localparam int unsigned DEPTH   = MAX_N + 1;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned DATA_W  = 20;

  localparam logic [DATA_W-1:0] MOD_RESET = DATA_W'(1000000);
  localparam logic [DATA_W-1:0] MOD_MIN   = DATA_W'(2);

endpackage

[rtl/bpcm_ram.sv]
// ----------------------------------------------------------------------------
// bpcm_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bpcm_ram #(
  parameter int unsigned DEPTH  = 1025,
  parameter int unsigned ADDR_W = 11,
  parameter int unsigned DATA_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/bpcm_addmod.sv]
// ----------------------------------------------------------------------------
// bpcm_addmod
// Modular adder: both operands are below the modulus, so one conditional
// subtraction brings the sum back into range.
// ----------------------------------------------------------------------------
module bpcm_addmod (
  input  logic [bpcm_pkg::DATA_W-1:0] a,
  input  logic [bpcm_pkg::DATA_W-1:0] b,
  input  logic [bpcm_pkg::DATA_W-1:0] m,
  output logic [bpcm_pkg::DATA_W-1:0] sum
);

  logic [bpcm_pkg::DATA_W:0] raw;
  logic [bpcm_pkg::DATA_W:0] red;

  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    red = raw - {1'b0, m};
    sum = (raw >= {1'b0, m}) ? red[bpcm_pkg::DATA_W-1:0] : raw[bpcm_pkg::DATA_W-1:0];
  end

endmodule

[rtl/bounded_partition_count_mod.sv]
// A query clears table entries 0..n, performs U table updates and reads entry n, where n is
// min(total, 1024), L is min(largest_part, n) and U = sum over p = 1..L of
// (n - p + 1). Each update passes through a read state and a write state on the
// single table write port and adder. A new query is taken only in idle;
// a stalled result delays the next.
// Reset (rst, synchronous) clears control state and sets the modulus to 1000000.
// ----------------------------------------------------------------------------
// bounded_partition_count_mod
// Counts partitions of a total into parts no larger than a limit, modulo a
// configurable modulus, by sweeping a one-dimensional ways table.
// ----------------------------------------------------------------------------
module bounded_partition_count_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,       // modulus
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,         // [10:0] total, [21:11] largest_part, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata          // [19:0] count, zero pad
);

  localparam int unsigned AW = bpcm_pkg::ADDR_W;
  localparam int unsigned DW = bpcm_pkg::DATA_W;
  localparam logic [AW-1:0] NMAX = AW'(bpcm_pkg::MAX_N);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_RD    = 6'b000100,
    ST_WR    = 6'b001000,
    ST_FRD   = 6'b010000,
    ST_FWAIT = 6'b100000
  } state_t;

  state_t          state;
  logic [DW-1:0]   modulus;
  logic [DW-1:0]   mod_eff;
  logic [AW-1:0]   n_reg;
  logic [AW-1:0]   lim_reg;
  logic [AW-1:0]   part_index;
  logic [AW-1:0]   position_index;
  logic [DW-1:0]   count;

  logic [AW-1:0]   in_total;
  logic [AW-1:0]   in_limit;
  logic [AW-1:0]   n_sat;
  logic [AW-1:0]   lim_sat;
  logic            ram_we;
  logic [DW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   raddr_a;
  logic [DW-1:0]   rdata_a;
  logic [DW-1:0]   rdata_b;
  logic [DW-1:0]   sum;
  logic            out_free;

  assign in_total = s_tdata[10:0];
  assign in_limit = s_tdata[21:11];
  assign n_sat    = (in_total > NMAX) ? NMAX : in_total;
  assign lim_sat  = (in_limit > n_sat) ? n_sat : in_limit;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {4'b0, count};

  // Port a serves both the update reads and the final read of entry n.
  assign ram_re    = (state == ST_RD) || (state == ST_FRD);
  assign raddr_a   = (state == ST_FRD) ? n_reg : position_index;
  assign ram_we    = (state == ST_CLEAR) || (state == ST_WR);
  assign ram_wdata = (state == ST_CLEAR) ? ((position_index == '0) ? DW'(1) : '0) : sum;

  bpcm_ram #(
    .DEPTH  (bpcm_pkg::DEPTH),
    .ADDR_W (AW),
    .DATA_W (DW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (position_index),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (raddr_a),
    .raddr_b (position_index - part_index),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bpcm_addmod u_add (
    .a   (rdata_a),
    .b   (rdata_b),
    .m   (mod_eff),
    .sum (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= bpcm_pkg::MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  // A result is raised as the last state hands it over and dropped at its transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FWAIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      part_index     <= '0;
      position_index <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            n_reg          <= n_sat;
            lim_reg        <= lim_sat;
            mod_eff        <= (modulus < bpcm_pkg::MOD_MIN) ? bpcm_pkg::MOD_MIN : modulus;
            position_index <= '0;
            state          <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (position_index == n_reg) begin
            if (lim_reg == '0) begin
              state <= ST_FRD;
            end else begin
              part_index     <= AW'(1);
              position_index <= AW'(1);
              state          <= ST_RD;
            end
          end else begin
            position_index <= position_index + AW'(1);
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (position_index == n_reg) begin
            if (part_index == lim_reg) begin
              state <= ST_FRD;
            end else begin
              // Next part size starts its sweep at its own position.
              part_index     <= part_index + AW'(1);
              position_index <= part_index + AW'(1);
              state          <= ST_RD;
            end
          end else begin
            position_index <= position_index + AW'(1);
            state          <= ST_RD;
          end
        end
        ST_FRD: begin
          state <= ST_FWAIT;
        end
        ST_FWAIT: begin
          if (out_free) begin
            count <= rdata_a;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bpcm_checker.sv]
// ----------------------------------------------------------------------------
// bpcm_checker
// Port-level checks on the bounded partition counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_partition_count_mod_assert.svh"

module bpcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result holds its value.
  `BPCM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // The block works on one query at a time.
  `BPCM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")

  // A new result appears only as the block returns to idle.
  `BPCM_ASSERT_SAME(a_result_at_idle, $rose(m_tvalid), s_tready, "result without return to idle")

  // Every count lies below a 20-bit modulus, and the pad bits stay zero.
  `BPCM_ASSERT_SAME(a_count_range, m_tvalid, (m_tdata[19:0] != 20'hFFFFF) && (m_tdata[23:20] == 4'h0), "count out of range")

endmodule

bind bounded_partition_count_mod bpcm_checker u_bpcm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tb_bounded_partition_count_mod.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_partition_count_mod
// Streams (total, largest part) queries into the partition counter under
// several moduli and compares every count against a table-based predictor
// held in a small scoreboard. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_bounded_partition_count_mod;

  class partition_scoreboard;
    logic [bpcm_pkg::DATA_W-1:0] modulus = bpcm_pkg::MOD_RESET;
    logic [bpcm_pkg::DATA_W-1:0] expected_counts [$];
    int unsigned mismatches;

    function void write_modulus(input logic [bpcm_pkg::DATA_W-1:0] value);
      modulus = value;
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction

    // Builds the ways table the same way the block does: parts in ascending
    // order, each sum reduced by one conditional subtraction.
    function logic [bpcm_pkg::DATA_W-1:0] count_partitions(input logic [10:0] total,
                                                           input logic [10:0] largest_part);
      logic [bpcm_pkg::DATA_W-1:0] ways [0:bpcm_pkg::MAX_N];
      int unsigned n, lim, m, sum, p, j;
      n = (total > bpcm_pkg::MAX_N) ? bpcm_pkg::MAX_N : total;
      lim = (largest_part > n) ? n : largest_part;
      m = (modulus < bpcm_pkg::MOD_MIN) ? bpcm_pkg::MOD_MIN : modulus;
      ways[0] = bpcm_pkg::DATA_W'(1);
      for (j = 1; j <= n; j++) ways[j] = '0;
      for (p = 1; p <= lim; p++) begin
        for (j = p; j <= n; j++) begin
          sum = ways[j] + ways[j - p];
          if (sum >= m) sum = sum - m;
          ways[j] = sum[bpcm_pkg::DATA_W-1:0];
        end
      end
      return ways[n];
    endfunction

    function void note_query(input logic [10:0] total, input logic [10:0] largest_part);
      expected_counts.push_back(count_partitions(total, largest_part));
    endfunction

    function void check_count(input logic [bpcm_pkg::DATA_W-1:0] actual);
      logic [bpcm_pkg::DATA_W-1:0] expected;
      if (expected_counts.size() == 0) begin
        $error("count: no query outstanding, actual %0d", actual);
        mismatches++;
      end else begin
        expected = expected_counts.pop_front();
        if (actual !== expected) begin
          $error("count: expected %0d, actual %0d", expected, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [10:0] total, [21:11] largest_part, zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [19:0] count, zero pad

  partition_scoreboard sb = new();
  int unsigned burst_left;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_cycles;

  bounded_partition_count_mod i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // The receiver rotates through a stall pattern and now and then picks a new
  // one; a quarter of the patterns keep it ready all the time.
  always @(posedge clk) begin
    if (pattern_cycles == 0) begin
      pattern_cycles <= $urandom_range(8, 80);
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      pattern_cycles <= pattern_cycles - 1;
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
    end
    m_tready <= ready_pattern[0];
  end

  // Results are checked before a new query is noted, so a result and an input
  // transaction at the same edge never pair up wrongly.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_modulus(cfg_wdata);
      if (m_tvalid && m_tready) sb.check_count(m_tdata[19:0]);
      if (s_tvalid && s_tready) sb.note_query(s_tdata[10:0], s_tdata[21:11]);
    end
  end

  task automatic send_query(input logic [10:0] total, input logic [10:0] largest_part);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, largest_part, total};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly small totals so that each query stays short; some full-range totals
  // with tiny limits and some medium totals with any limit.
  task automatic send_random_query();
    logic [10:0] total, largest_part;
    int unsigned shape;
    shape = $urandom_range(0, 9);
    if (shape < 7) begin
      total = 11'($urandom_range(0, 40));
      largest_part = $urandom_range(0, 1) ? 11'($urandom) : 11'($urandom_range(0, 12));
    end else if (shape < 9) begin
      total = 11'($urandom);
      largest_part = 11'($urandom_range(0, 3));
    end else begin
      total = 11'($urandom_range(41, 120));
      largest_part = 11'($urandom);
    end
    send_query(total, largest_part);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_modulus(input logic [19:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [19:0] moduli [7];
    moduli = '{20'd2, 20'd0, 20'd1, 20'hFFFFF, 20'd0, 20'd0, 20'd1000000};
    moduli[4] = 20'($urandom_range(3, 1048574));
    moduli[5] = 20'($urandom_range(3, 100));
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed queries under the reset modulus: zero totals, zero limits,
    // limits above the total, saturated totals and all-ones fields.
    send_query(11'd0, 11'd0);
    send_query(11'd0, 11'd2047);
    send_query(11'd0, 11'd5);
    send_query(11'd1, 11'd0);
    send_query(11'd1, 11'd1);
    send_query(11'd5, 11'd0);
    send_query(11'd5, 11'd3);
    send_query(11'd5, 11'd5);
    send_query(11'd5, 11'd2047);
    send_query(11'd10, 11'd4);
    send_query(11'd2047, 11'd0);
    send_query(11'd2047, 11'd1);
    send_query(11'd2047, 11'd2);
    send_query(11'd1024, 11'd3);
    send_query(11'd1025, 11'd2);
    send_query(11'd1023, 11'd1);
    send_query(11'd1536, 11'd1);
    send_query(11'd200, 11'd200);
    send_query(11'd60, 11'd2047);
    send_query(11'd100, 11'd10);
    send_query(11'd30, 11'd1);

    // Each modulus change waits for the block to drain completely.
    foreach (moduli[i]) begin
      write_modulus(moduli[i]);
      send_query(11'd0, 11'd0);
      send_query(11'd40, 11'd40);
      repeat (9) send_random_query();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
